// ===== design/wsunm_pkg.sv =====
package wsunm_pkg;

  localparam logic [7:0] HDR_TEXT_FINAL = 8'h81;
  localparam int LEN_W = 7;
  localparam int MASK_BYTES = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_MASK,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] mask;
    logic       last;
    logic       empty;
    logic       err;
  } qentry_t;

endpackage

// ===== design/websocket_text_frame_unmasker.sv =====
// Unmasks client-to-server WebSocket final text frames fed one byte per transaction. Each
// frame is the header byte 0x81, a length byte (low seven bits used), four mask key bytes
// and the payload, and every payload byte comes out XORed with its mask key byte. A
// zero-length frame gives one empty-message result, and a wrong header byte gives one
// error result after which the block drops all input until reset. The block takes one
// byte per clock cycle while the queue has room and delivers one result per cycle while
// the output is ready. A result passes from the parser into the two-entry queue and then
// into the output register before it is offered. When the output is held off, the queue
// and the output register absorb three results before the input stalls.
module websocket_text_frame_unmasker #(
  parameter int QUEUE_DEPTH = wsunm_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic       out_last_of_message,
  output logic       out_empty_message,
  output logic       out_frame_error
);

  wsunm_pkg::qentry_t push_entry;
  wsunm_pkg::qentry_t head;
  logic               push;
  logic               full;
  logic               pop;
  logic               not_empty;

  wsunm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (full),
    .q_push   (push),
    .q_entry  (push_entry)
  );

  wsunm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  wsunm_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_not_empty         (not_empty),
    .q_head              (head),
    .q_pop               (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_payload_byte    (out_payload_byte),
    .out_last_of_message (out_last_of_message),
    .out_empty_message   (out_empty_message),
    .out_frame_error     (out_frame_error)
  );

endmodule

// ===== design/wsunm_front.sv =====
module wsunm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               q_full,
  output logic               q_push,
  output wsunm_pkg::qentry_t q_entry
);

  localparam int KW = $clog2(wsunm_pkg::MASK_BYTES);

  wsunm_pkg::phase_t                  phase_r, phase_nxt;
  logic [wsunm_pkg::MASK_BYTES-1:0][7:0] key_r, key_nxt;
  logic [wsunm_pkg::LEN_W-1:0]        rem_r, rem_nxt;
  logic [KW-1:0]                      pos_r, pos_nxt;
  logic [KW-1:0]                      cnt_r, cnt_nxt;
  logic                               err_r, err_nxt;
  logic                               accept;
  logic                               last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign last     = (rem_r <= wsunm_pkg::LEN_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsunm_pkg::PH_HEADER;
      rem_r   <= '0;
      pos_r   <= '0;
      cnt_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_comb begin
    phase_nxt = phase_r;
    key_nxt   = key_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    q_push    = 1'b0;
    q_entry   = '0;
    if (accept && !err_r) begin
      case (phase_r)
        wsunm_pkg::PH_HEADER: begin
          if (in_byte != wsunm_pkg::HDR_TEXT_FINAL) begin
            err_nxt     = 1'b1;
            q_push      = 1'b1;
            q_entry.err = 1'b1;
          end else begin
            phase_nxt = wsunm_pkg::PH_LENGTH;
          end
        end
        wsunm_pkg::PH_LENGTH: begin
          rem_nxt   = in_byte[wsunm_pkg::LEN_W-1:0];
          pos_nxt   = '0;
          cnt_nxt   = '0;
          key_nxt   = '0;
          phase_nxt = wsunm_pkg::PH_MASK;
        end
        wsunm_pkg::PH_MASK: begin
          key_nxt[cnt_r] = in_byte;
          if (cnt_r == KW'(wsunm_pkg::MASK_BYTES - 1)) begin
            cnt_nxt = '0;
            if (rem_r == '0) begin
              phase_nxt     = wsunm_pkg::PH_HEADER;
              q_push        = 1'b1;
              q_entry.last  = 1'b1;
              q_entry.empty = 1'b1;
            end else begin
              phase_nxt = wsunm_pkg::PH_PAYLOAD;
            end
          end else begin
            cnt_nxt = cnt_r + KW'(1);
          end
        end
        wsunm_pkg::PH_PAYLOAD: begin
          q_push       = 1'b1;
          q_entry.data = in_byte;
          q_entry.mask = key_r[pos_r];
          q_entry.last = last;
          pos_nxt      = pos_r + KW'(1);
          rem_nxt      = last ? '0 : rem_r - wsunm_pkg::LEN_W'(1);
          if (last) begin
            phase_nxt = wsunm_pkg::PH_HEADER;
          end
        end
        default: begin
          phase_nxt = wsunm_pkg::PH_HEADER;
        end
      endcase
    end
  end

endmodule

// ===== design/wsunm_queue.sv =====
module wsunm_queue #(
  parameter int DEPTH = wsunm_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wsunm_pkg::qentry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output wsunm_pkg::qentry_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsunm_pkg::qentry_t mem_r [DEPTH];
  logic [AW-1:0]      wptr_r, wptr_nxt;
  logic [AW-1:0]      rptr_r, rptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

endmodule

// ===== design/wsunm_back.sv =====
module wsunm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  wsunm_pkg::qentry_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_payload_byte,
  output logic               out_last_of_message,
  output logic               out_empty_message,
  output logic               out_frame_error
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       empty_r;
  logic       err_r;

  assign q_pop = q_not_empty && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      byte_r  <= q_head.data ^ q_head.mask;
      last_r  <= q_head.last;
      empty_r <= q_head.empty;
      err_r   <= q_head.err;
    end
  end

  assign out_valid           = valid_r;
  assign out_payload_byte    = byte_r;
  assign out_last_of_message = last_r;
  assign out_empty_message   = empty_r;
  assign out_frame_error     = err_r;

endmodule

// ===== design/wsunm_checker.sv =====
module wsunm_props (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_payload_byte,
  input logic       out_last_of_message,
  input logic       out_empty_message,
  input logic       out_frame_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_last_of_message) && $stable(out_empty_message)
      && $stable(out_frame_error))
    else $error("result changed while stalled");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_error |-> !out_last_of_message && !out_empty_message
      && out_payload_byte == 8'h00)
    else $error("error result carries other fields");

  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_message |-> out_last_of_message && out_payload_byte == 8'h00)
    else $error("empty message result malformed");

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_frame_error |=> !out_valid)
    else $error("result after frame error");

endmodule

bind websocket_text_frame_unmasker wsunm_props u_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_payload_byte    (out_payload_byte),
  .out_last_of_message (out_last_of_message),
  .out_empty_message   (out_empty_message),
  .out_frame_error     (out_frame_error)
);
